FILE: rtl/tac_pair_qualify_top_two_assert.svh
// Assertion macros shared by the pair qualify RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef TAC_PAIR_QUALIFY_TOP_TWO_ASSERT_SVH
`define TAC_PAIR_QUALIFY_TOP_TWO_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define TPQTT_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tpqtt invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define TPQTT_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpqtt implication violated");

// Consequent holds in the cycle after the antecedent.
`define TPQTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpqtt next-cycle check violated");

`endif

FILE: rtl/tpqtt_pkg.sv
// Package for the pair qualify block: widths, register indexes, limit struct.
// No dependencies; used by tpqtt_qualify and tac_pair_qualify_top_two.
`timescale 1ns / 1ps

package tpqtt_pkg;

    localparam int unsigned BOARD_W   = 2;
    localparam int unsigned TAC_W     = 12;
    localparam int unsigned SUM_W     = TAC_W + 1;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned PAIRS_PER_BOARD = 8;
    localparam logic [IDX_W-1:0] PAIRS_LIMIT = IDX_W'(PAIRS_PER_BOARD);
    localparam logic [IDX_W-1:0] INDEX_MAX   = '1;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAC_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAC_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAC_DIFF = 2'd2;

    localparam logic [TAC_W-1:0] TAC_LOW_RESET  = 12'd100;
    localparam logic [TAC_W-1:0] TAC_HIGH_RESET = 12'd4000;
    localparam logic [TAC_W-1:0] TAC_DIFF_RESET = 12'd600;

    typedef struct packed {
        logic [TAC_W-1:0] low;
        logic [TAC_W-1:0] high;
        logic [TAC_W-1:0] diff;
    } tac_limits_t;

endpackage

FILE: rtl/tpqtt_qualify.sv
// Window and difference check of one sample pair; yields the sum or zero.
// Depends on tpqtt_pkg.
`timescale 1ns / 1ps

module tpqtt_qualify
    import tpqtt_pkg::*;
(
    input  tac_limits_t       limits,
    input  logic [TAC_W-1:0]  tac_first,
    input  logic [TAC_W-1:0]  tac_second,
    output logic [SUM_W-1:0]  pair_sum
);

    logic [TAC_W-1:0] abs_diff;
    logic             first_ok;
    logic             second_ok;
    logic             diff_ok;

    always_comb
    begin
        abs_diff  = (tac_first > tac_second) ? (tac_first - tac_second)
                                             : (tac_second - tac_first);
        first_ok  = (tac_first >= limits.low) && (tac_first <= limits.high);
        second_ok = (tac_second >= limits.low) && (tac_second <= limits.high);
        diff_ok   = (abs_diff <= limits.diff);
        if (first_ok && second_ok && diff_ok)
        begin
            pair_sum = {1'b0, tac_first} + {1'b0, tac_second};
        end
        else
        begin
            pair_sum = '0;
        end
    end

endmodule

FILE: rtl/tac_pair_qualify_top_two.sv
// Pair qualify with running top-two tracker, one readout board at a time.
// Path from input request to result request: input register, tracker update, result register.
// Throughput: one request per cycle without result stalls; that single tracker update sets it.
// Reset (rst_n low, asynchronous): tracker cleared, limits back to 100 / 4000 / 600.
// No clearing pass; requests are taken in the first cycle after reset.
// Depends on tpqtt_pkg, tpqtt_qualify and tac_pair_qualify_top_two_assert.svh.
`timescale 1ns / 1ps

`include "tac_pair_qualify_top_two_assert.svh"

module tac_pair_qualify_top_two
    import tpqtt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Pair requests
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] board, [13:2] tac_first, [25:14] tac_second, [31:26] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,   // last_pair

    // Results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] board_echo, [14:2] pair_sum, [18:15] best_position,
    // [22:19] second_position, [23] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,   // board_done

    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TAC_W-1:0]      cfg_data
);

    // Configuration registers
    tac_limits_t limits_reg;

    // Input stage
    logic                s1_valid_reg;
    logic [BOARD_W-1:0]  s1_board_reg;
    logic [TAC_W-1:0]    s1_first_reg;
    logic [TAC_W-1:0]    s1_second_reg;
    logic                s1_last_reg;

    // Tracker state
    logic [IDX_W-1:0]    pair_index_reg, pair_index_next;
    logic [SUM_W-1:0]    best_sum_reg, best_sum_next;
    logic [IDX_W-1:0]    best_pos_reg, best_pos_next;
    logic [SUM_W-1:0]    second_sum_reg, second_sum_next;
    logic [IDX_W-1:0]    second_pos_reg, second_pos_next;

    // Result stage
    logic                out_valid_reg, out_valid_next;
    logic [BOARD_W-1:0]  out_board_reg;
    logic [SUM_W-1:0]    out_sum_reg;
    logic [IDX_W-1:0]    out_best_reg;
    logic [IDX_W-1:0]    out_second_reg;
    logic                out_last_reg;

    logic                advance;
    logic [SUM_W-1:0]    pair_sum;
    logic                rank_en;
    logic [IDX_W-1:0]    pos;
    logic [SUM_W-1:0]    ranked_best_sum;
    logic [IDX_W-1:0]    ranked_best_pos;
    logic [SUM_W-1:0]    ranked_second_sum;
    logic [IDX_W-1:0]    ranked_second_pos;

    // Move the held request into the result register whenever that slot is free
    // or is being drained this cycle; the input register refills in the same edge.
    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    //--------------------------------------------------------------------
    // Configuration: writes to an index beyond the list are dropped
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.low  <= TAC_LOW_RESET;
            limits_reg.high <= TAC_HIGH_RESET;
            limits_reg.diff <= TAC_DIFF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TAC_LOW:  limits_reg.low  <= cfg_data;
                CFG_TAC_HIGH: limits_reg.high <= cfg_data;
                CFG_TAC_DIFF: limits_reg.diff <= cfg_data;
                default:      ;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Input register
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_board_reg  <= s_axis_tdata[BOARD_W-1:0];
            s1_first_reg  <= s_axis_tdata[BOARD_W +: TAC_W];
            s1_second_reg <= s_axis_tdata[BOARD_W+TAC_W +: TAC_W];
            s1_last_reg   <= s_axis_tlast;
        end
    end

    //--------------------------------------------------------------------
    // Qualification
    //--------------------------------------------------------------------
    tpqtt_qualify u_qualify
    (
        .limits     (limits_reg),
        .tac_first  (s1_first_reg),
        .tac_second (s1_second_reg),
        .pair_sum   (pair_sum)
    );

    //--------------------------------------------------------------------
    // Top-two ranking: a sum displaces an entry only if strictly larger,
    // so ties keep the earlier pair and a zero sum is never ranked.
    //--------------------------------------------------------------------
    always_comb
    begin
        rank_en           = (pair_index_reg < PAIRS_LIMIT);
        pos               = pair_index_reg + IDX_W'(1);
        ranked_best_sum   = best_sum_reg;
        ranked_best_pos   = best_pos_reg;
        ranked_second_sum = second_sum_reg;
        ranked_second_pos = second_pos_reg;
        if (rank_en)
        begin
            priority if (best_sum_reg < pair_sum)
            begin
                ranked_second_sum = best_sum_reg;
                ranked_second_pos = best_pos_reg;
                ranked_best_sum   = pair_sum;
                ranked_best_pos   = pos;
            end
            else if (second_sum_reg < pair_sum)
            begin
                ranked_second_sum = pair_sum;
                ranked_second_pos = pos;
            end
            else
            begin
                // Hold both entries: the sum does not beat the second
                ranked_second_sum = second_sum_reg;
                ranked_second_pos = second_pos_reg;
            end
        end
    end

    // Advance the tracker; pair_index saturates so ranking stays off past the
    // board size, and the last pair clears everything for the next board.
    always_comb
    begin
        pair_index_next = pair_index_reg;
        best_sum_next   = best_sum_reg;
        best_pos_next   = best_pos_reg;
        second_sum_next = second_sum_reg;
        second_pos_next = second_pos_reg;
        if (advance)
        begin
            if (s1_last_reg)
            begin
                pair_index_next = '0;
                best_sum_next   = '0;
                best_pos_next   = '0;
                second_sum_next = '0;
                second_pos_next = '0;
            end
            else
            begin
                if (pair_index_reg != INDEX_MAX)
                begin
                    pair_index_next = pair_index_reg + IDX_W'(1);
                end
                best_sum_next   = ranked_best_sum;
                best_pos_next   = ranked_best_pos;
                second_sum_next = ranked_second_sum;
                second_pos_next = ranked_second_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_index_reg <= '0;
            best_sum_reg   <= '0;
            best_pos_reg   <= '0;
            second_sum_reg <= '0;
            second_pos_reg <= '0;
        end
        else
        begin
            pair_index_reg <= pair_index_next;
            best_sum_reg   <= best_sum_next;
            best_pos_reg   <= best_pos_next;
            second_sum_reg <= second_sum_next;
            second_pos_reg <= second_pos_next;
        end
    end

    //--------------------------------------------------------------------
    // Result register: report the tracker as it stands after ranking
    //--------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_board_reg  <= s1_board_reg;
            out_sum_reg    <= pair_sum;
            out_best_reg   <= ranked_best_pos;
            out_second_reg <= ranked_second_pos;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_second_reg, out_best_reg, out_sum_reg, out_board_reg};
    assign m_axis_tlast  = out_last_reg;

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    `TPQTT_ASSERT_ALWAYS(a_best_ge_second, best_sum_reg >= second_sum_reg)
    `TPQTT_ASSERT_IMPLIES(a_second_needs_best, second_pos_reg != '0, best_pos_reg != '0)
    `TPQTT_ASSERT_IMPLIES(a_distinct_pos, best_pos_reg != '0,
                          best_pos_reg != second_pos_reg)
    `TPQTT_ASSERT_IMPLIES(a_pos_in_board, best_pos_reg != '0,
                          (best_pos_reg <= PAIRS_LIMIT) && (best_pos_reg <= pair_index_reg))
    `TPQTT_ASSERT_NEXT(a_clear_on_last, advance && s1_last_reg,
                       (pair_index_reg == '0) && (best_sum_reg == '0) && (second_sum_reg == '0))

endmodule

FILE: dv/tb_tac_pair_qualify_top_two.sv
// Self-checking testbench for the pair qualify block with its top-two tracker.
// Drives pair requests and limit writes, predicts every result and compares field by field.
// Depends on tpqtt_pkg and tac_pair_qualify_top_two.
`timescale 1ns / 1ps

module tb_tac_pair_qualify_top_two
    import tpqtt_pkg::*;
;

    localparam int LONG_HOLD_CYCLES = 64;
    localparam int REPORT_LIMIT     = 10;

    typedef struct {
        logic [BOARD_W-1:0] board;
        logic [TAC_W-1:0]   tac_first;
        logic [TAC_W-1:0]   tac_second;
        logic               last_pair;
    } pair_req_t;

    typedef struct {
        logic [BOARD_W-1:0] board_echo;
        logic [SUM_W-1:0]   pair_sum;
        logic [IDX_W-1:0]   best_position;
        logic [IDX_W-1:0]   second_position;
        logic               board_done;
    } pair_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TAC_LOW;
    logic [TAC_W-1:0]      cfg_data = '0;

    tac_pair_qualify_top_two u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Pair requests waiting to go out, and results owed by the block
    pair_req_t    pending_pairs[$];
    pair_result_t owed_results[$];
    pair_result_t oldest_owed;

    // Window limits as the block should hold them
    logic [TAC_W-1:0] lim_low  = TAC_LOW_RESET;
    logic [TAC_W-1:0] lim_high = TAC_HIGH_RESET;
    logic [TAC_W-1:0] lim_diff = TAC_DIFF_RESET;

    // Top-two tracker of the board in progress
    logic [IDX_W-1:0] trk_index      = '0;
    logic [SUM_W-1:0] trk_best_sum   = '0;
    logic [IDX_W-1:0] trk_best_pos   = '0;
    logic [SUM_W-1:0] trk_second_sum = '0;
    logic [IDX_W-1:0] trk_second_pos = '0;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int err_count     = 0;
    bit long_hold_req   = 1'b0;
    bit long_hold_taken = 1'b0;
    int hold_left       = 0;

    // Qualify one pair, rank its sum and return the result the block must report.
    function automatic pair_result_t rank_pair(input pair_req_t p);
        logic [TAC_W-1:0] gap;
        logic [SUM_W-1:0] total;
        logic [IDX_W-1:0] pos;
        pair_result_t     r;
        gap = (p.tac_first > p.tac_second) ? p.tac_first - p.tac_second
                                           : p.tac_second - p.tac_first;
        total = SUM_W'(p.tac_first) + SUM_W'(p.tac_second);
        if (p.tac_first < lim_low || p.tac_first > lim_high ||
            p.tac_second < lim_low || p.tac_second > lim_high || gap > lim_diff)
            total = '0;
        // Strictly larger only: ties keep the earlier pair, zero never ranks
        if (trk_index < PAIRS_LIMIT)
        begin
            pos = trk_index + 1'b1;
            if (trk_best_sum < total)
            begin
                trk_second_sum = trk_best_sum;
                trk_second_pos = trk_best_pos;
                trk_best_sum   = total;
                trk_best_pos   = pos;
            end
            else if (trk_second_sum < total)
            begin
                trk_second_sum = total;
                trk_second_pos = pos;
            end
        end
        if (trk_index != INDEX_MAX)
            trk_index = trk_index + 1'b1;
        r.board_echo      = p.board;
        r.pair_sum        = total;
        r.best_position   = trk_best_pos;
        r.second_position = trk_second_pos;
        r.board_done      = p.last_pair;
        if (p.last_pair)
        begin
            trk_index      = '0;
            trk_best_sum   = '0;
            trk_best_pos   = '0;
            trk_second_sum = '0;
            trk_second_pos = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            if (err_count < REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Clock: 20 ns period
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Pair request driver: hold a request until taken, then offer the next or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                owed_results.push_back(rank_pair(pending_pairs[0]));
                void'(pending_pairs.pop_front());
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_W'({pending_pairs[0].tac_second,
                                                 pending_pairs[0].tac_first,
                                                 pending_pairs[0].board});
                    s_axis_tlast  <= pending_pairs[0].last_pair;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result ready: random stalls, plus one long hold that backs up the block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (long_hold_req && !long_hold_taken)
        begin
            long_hold_taken <= 1'b1;
            hold_left       <= LONG_HOLD_CYCLES;
            m_axis_tready   <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Result monitor: compare every accepted result with the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (owed_results.size() == 0)
            begin
                if (err_count < REPORT_LIMIT)
                    $display("%0t: result with none owed, data %h", $time, m_axis_tdata);
                err_count++;
            end
            else
            begin
                oldest_owed = owed_results.pop_front();
                check_field("board_echo", oldest_owed.board_echo, m_axis_tdata[1:0]);
                check_field("pair_sum", oldest_owed.pair_sum, m_axis_tdata[14:2]);
                check_field("best_position", oldest_owed.best_position, m_axis_tdata[18:15]);
                check_field("second_position", oldest_owed.second_position,
                            m_axis_tdata[22:19]);
                check_field("board_done", oldest_owed.board_done, m_axis_tlast);
            end
        end
    end

    // Run limit
    initial
    begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic add_pair(input int board, input int first, input int second,
                            input bit last);
        pair_req_t p;
        p.board      = board[BOARD_W-1:0];
        p.tac_first  = first[TAC_W-1:0];
        p.tac_second = second[TAC_W-1:0];
        p.last_pair  = last;
        pending_pairs.push_back(p);
    endtask

    // Write one limit register and track it once the write is taken
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[TAC_W-1:0];
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TAC_LOW:  lim_low  = value[TAC_W-1:0];
            CFG_TAC_HIGH: lim_high = value[TAC_W-1:0];
            CFG_TAC_DIFF: lim_diff = value[TAC_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every pair is sent and every owed result has come back, then settle
    task automatic drain();
        do
            @(posedge clk);
        while (pending_pairs.size() != 0 || owed_results.size() != 0 || s_axis_tvalid);
        repeat (4) @(posedge clk);
    endtask

    // One phase: set the limits and idling, then send whole boards of random pairs.
    // Most pairs are built to land inside the window so the tracker sees real sums.
    task automatic run_phase(input int low, input int high, input int diff,
                             input int src_pct, input int snk_pct,
                             input int n_items, input bit with_hold);
        int sent;
        int board_len;
        int cur_board;
        int first;
        int second;
        int lo2;
        int hi2;
        int sel;
        write_limit(CFG_TAC_LOW, low);
        write_limit(CFG_TAC_HIGH, high);
        write_limit(CFG_TAC_DIFF, diff);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        if (with_hold)
            long_hold_req = 1'b1;
        sent = 0;
        while (sent < n_items)
        begin
            sel = $urandom_range(99);
            board_len = (sel < 85) ? $urandom_range(8, 1)
                      : (sel < 95) ? $urandom_range(12, 9) : $urandom_range(20, 13);
            cur_board = $urandom_range(3);
            for (int k = 0; k < board_len; k++)
            begin
                if (lim_low <= lim_high && $urandom_range(99) < 75)
                begin
                    first = $urandom_range(lim_high, lim_low);
                    lo2 = (first - int'(lim_diff) > int'(lim_low))
                          ? first - int'(lim_diff) : int'(lim_low);
                    hi2 = (first + int'(lim_diff) < int'(lim_high))
                          ? first + int'(lim_diff) : int'(lim_high);
                    second = $urandom_range(hi2, lo2);
                    // Nudge some pairs just past the window or the difference limit
                    if ($urandom_range(9) == 0)
                        second = $urandom_range(1) ? hi2 + 1 : lo2 - 1;
                    if ($urandom_range(1))
                    begin
                        lo2    = first;
                        first  = second;
                        second = lo2;
                    end
                end
                else
                begin
                    first  = $urandom_range(4095);
                    second = $urandom_range(4095);
                end
                // Drop in an occasional board change in the middle of a board
                if ($urandom_range(9) == 0)
                    cur_board = $urandom_range(3);
                add_pair(cur_board, first, second, k == board_len - 1);
            end
            sent += board_len;
        end
        drain();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed board at the reset limits 100 / 4000 / 600
        add_pair(0, 100, 100, 1'b0);    // lowest passing samples
        add_pair(0, 99, 200, 1'b0);     // first just below the window
        add_pair(0, 4000, 3400, 1'b0);  // top of window, difference right at the limit
        add_pair(0, 4001, 3500, 1'b0);  // first just above the window
        add_pair(0, 1000, 1601, 1'b0);  // difference one past the limit
        add_pair(0, 3700, 3700, 1'b0);  // ties the best, lands as second
        add_pair(3, 3700, 3700, 1'b0);  // ties both, board changes mid-board
        add_pair(3, 0, 0, 1'b0);        // lowest samples fail
        add_pair(3, 2000, 2000, 1'b1);  // ninth pair: summed, not ranked
        add_pair(2, 4095, 0, 1'b1);     // single-pair board, extremes
        add_pair(1, 50, 50, 1'b0);      // zero sum first, never ranked
        add_pair(1, 2730, 2730, 1'b0);  // alternating bit patterns
        add_pair(1, 1365, 1365, 1'b0);
        add_pair(1, 0, 4095, 1'b0);
        add_pair(1, 4095, 4095, 1'b1);
        drain();

        run_phase(0, 4095, 4095, 0, 0, 80, 1'b0);      // widest window
        run_phase(500, 3500, 200, 85, 0, 70, 1'b0);    // sender mostly idle
        run_phase(4095, 0, 0, 0, 85, 50, 1'b0);        // inverted window, receiver stalls
        run_phase(1000, 1000, 0, 31, 31, 60, 1'b0);    // single-value window, many ties
        run_phase($urandom_range(1500), $urandom_range(4095, 2500), $urandom_range(4095),
                  0, 0, 80, 1'b1);                     // long receiver hold
        run_phase($urandom_range(1500), $urandom_range(4095, 2500), $urandom_range(800),
                  0, 0, 100, 1'b0);

        repeat (10) @(posedge clk);
        if (err_count == 0 && owed_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/tpqtt_pkg.sv
rtl/tpqtt_qualify.sv
rtl/tac_pair_qualify_top_two.sv
dv/tb_tac_pair_qualify_top_two.sv
